[hdl/ikdt_pkg.sv]
// Shared types and constants for the in-flight key dedup table.
`default_nettype none

package ikdt_pkg;

  localparam int unsigned KeyW     = 64;  // width of the key field on the stream
  localparam int unsigned OccW     = 5;   // width of the occupancy field
  localparam int unsigned OutDataW = 8;   // occupancy padded to whole bytes

  typedef enum logic {
    ACT_MARK  = 1'b0,
    ACT_CLEAR = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_CLEARED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    action_e           action;
    logic [KeyW-1:0]   key;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [OccW-1:0]   occupancy;
  } resp_t;

endpackage

`default_nettype wire

[hdl/ikdt_in_reg.sv]
// Input holding register for request beats.
`default_nettype none

module ikdt_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ikdt_pkg::req_t in_req_i,
  output logic               req_valid_o,
  input  wire logic          req_take_i,
  output ikdt_pkg::req_t     req_o
);

  logic           valid_q, valid_d;
  ikdt_pkg::req_t req_q;

  // Refill in the same cycle the held beat moves on.
  assign in_ready_o = !valid_q || req_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  // A held beat that is not taken stays held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !req_take_i |=> valid_q && $stable(req_q))
    else $error("held request lost while stalled");

endmodule

`default_nettype wire

[hdl/ikdt_table.sv]
// Associative key table: parallel compare, free-slot pick and update.
`default_nettype none

module ikdt_table #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_fire_i,
  input  wire ikdt_pkg::req_t req_i,
  output ikdt_pkg::resp_t     resp_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0] keys_q [ENTRIES];
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [CntW-1:0]     count_q, count_d;

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  hit_oh;
  logic [ENTRIES-1:0]  free_oh;
  logic                hit;
  logic                full;
  logic                do_insert;
  logic                do_clear;
  logic [KEY_BITS-1:0] key;

  assign key = req_i.key[KEY_BITS-1:0];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (keys_q[i] == key);
    end
  end

  // Lowest set bit of match, lowest clear bit of valid.
  assign hit_oh  = match & (~match + ENTRIES'(1));
  assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));
  assign hit     = |match;
  assign full    = &valid_q;

  assign do_insert = (req_i.action == ikdt_pkg::ACT_MARK) && !hit && !full;
  assign do_clear  = (req_i.action == ikdt_pkg::ACT_CLEAR) && hit;

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (do_insert) begin
      valid_d = valid_q | free_oh;
      count_d = count_q + CntW'(1);
    end else if (do_clear) begin
      valid_d = valid_q & ~hit_oh;
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    priority if (req_i.action == ikdt_pkg::ACT_MARK) begin
      priority if (hit) resp_o.status = ikdt_pkg::ST_DUPLICATE;
      else if (full)    resp_o.status = ikdt_pkg::ST_FULL;
      else              resp_o.status = ikdt_pkg::ST_INSERTED;
    end else begin
      resp_o.status = hit ? ikdt_pkg::ST_CLEARED : ikdt_pkg::ST_NOT_FOUND;
    end
    resp_o.occupancy = ikdt_pkg::OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (req_fire_i) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  // Key store has no reset; only valid slots are ever compared.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (req_fire_i && do_insert && free_oh[i]) begin
        keys_q[i] <= key;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == 32'($countones(valid_q)))
    else $error("occupancy count drifted from valid bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key held in more than one slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire_i && do_clear |=> count_q == $past(count_q) - CntW'(1))
    else $error("clear did not drop occupancy");

endmodule

`default_nettype wire

[hdl/inflight_key_dedup_table.sv]
// Top level of the in-flight key dedup table.
//
//  channel   | dir | beat contents
//  ----------+-----+----------------------------------------------------------
//  s_axis    | in  | tuser: action (0 mark, 1 clear); tdata: lookup_key
//  m_axis    | out | tuser: status code; tdata: occupancy after the request
//
// One request beat gives one result beat. A beat is held in the input register,
// is compared against all slots at once, and its result lands in the output
// register while the table updates on that same edge; one beat per cycle is
// sustained while m_axis_tready_i stays high.
// Reset empties the table (valid bits and count); stored keys are not cleared.
// A stalled result holds the input register; the input side stays ready while
// the held beat can move on in that cycle.
`default_nettype none

module inflight_key_dedup_table #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [ikdt_pkg::KeyW-1:0]      s_axis_tdata_i,  // [63:0] lookup_key
  input  wire logic                           s_axis_tuser_i,  // [0] action
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [ikdt_pkg::OutDataW-1:0]       m_axis_tdata_o,  // [4:0] occupancy, [7:5] zero
  output logic [2:0]                          m_axis_tuser_o   // [2:0] status
);

  ikdt_pkg::req_t  in_req;
  ikdt_pkg::req_t  req;
  ikdt_pkg::resp_t resp;
  ikdt_pkg::resp_t out_q;
  logic            req_valid;
  logic            advance;
  logic            out_valid_q, out_valid_d;

  assign in_req.action = ikdt_pkg::action_e'(s_axis_tuser_i);
  assign in_req.key    = s_axis_tdata_i;

  // Held request moves on when the result slot is empty or being drained.
  assign advance = req_valid && (!out_valid_q || m_axis_tready_i);

  ikdt_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_req_i    (in_req),
    .req_valid_o (req_valid),
    .req_take_i  (advance),
    .req_o       (req)
  );

  ikdt_table #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_fire_i (advance),
    .req_i      (req),
    .resp_o     (resp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= resp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = ikdt_pkg::OutDataW'(out_q.occupancy);

  // Input side never takes a beat while the held one is stuck.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && req_valid && !advance))
    else $error("input accepted over a stalled request");

  // A request that moved on always shows up as a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o)
    else $error("result missing after request advanced");

  // A stalled result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !advance)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
